// ===== sv/ise_pkg.sv =====
// Shared constants, codes and controller/datapath bundles for the interpolation search engine.
`timescale 1ns / 1ps

package ise_pkg;

   localparam int TABLE_DEPTH   = 1024;
   localparam int ADDR_WIDTH    = $clog2(TABLE_DEPTH);
   localparam int KEY_WIDTH     = 16;
   localparam int COUNT_WIDTH   = 11;
   localparam int INDEX_WIDTH   = 10;
   localparam int POS_WIDTH     = 10;
   // Range bounds need one extra bit for the upper end and a sign for minus one.
   localparam int RANGE_WIDTH   = ADDR_WIDTH + 2;
   localparam int PROD_WIDTH    = KEY_WIDTH + ADDR_WIDTH;
   localparam int DIV_STEPS     = ADDR_WIDTH;
   localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS + 1);

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef enum logic [1:0] {
      RD_LO,
      RD_HI,
      RD_P
   } rd_sel_type;

   typedef enum logic [1:0] {
      RES_NONE,
      RES_MISS,
      RES_LO,
      RES_P
   } res_sel_type;

   typedef struct packed {
      logic        wr_en;
      logic        init;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        ld_kl;
      logic        ld_mul;
      logic        div_load;
      logic        div_step;
      logic        p_from_lo;
      logic        p_from_quo;
      logic        lo_up;
      logic        hi_down;
      res_sel_type res_sel;
      logic        load_rsp;
   } ise_cmd_type;

   typedef struct packed {
      logic lo_le_hi;
      logic in_range;
      logic single;
      logic match_lo;
      logic flat;
      logic p_match;
      logic p_below;
   } ise_status_type;

endpackage

// ===== sv/ise_if.sv =====
// Valid/ready channel interfaces for search requests and responses.
`timescale 1ns / 1ps

interface ise_req_if import ise_pkg::*;;
   logic                         valid;
   logic                         ready;
   logic                         operation;
   logic [INDEX_WIDTH-1:0]       entry_index;
   logic signed [KEY_WIDTH-1:0]  key_value;

   modport source (output valid, operation, entry_index, key_value, input ready);
   modport sink   (input valid, operation, entry_index, key_value, output ready);
endinterface

interface ise_rsp_if import ise_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic                 found;
   logic [POS_WIDTH-1:0] position;

   modport source (output valid, found, position, input ready);
   modport sink   (input valid, found, position, output ready);
endinterface

// ===== sv/ise_datapath.sv =====
// Datapath: key memory, range registers, probe multiplier, restoring divider, result register.
`timescale 1ns / 1ps

module ise_datapath import ise_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [COUNT_WIDTH-1:0]      csr_write_data,
   input  logic [INDEX_WIDTH-1:0]      entry_index,
   input  logic signed [KEY_WIDTH-1:0] key_value,
   input  ise_cmd_type                 cmd,
   output ise_status_type              status,
   output logic                        found,
   output logic [POS_WIDTH-1:0]        position
);

   logic signed [KEY_WIDTH-1:0]   key_mem [TABLE_DEPTH];
   logic signed [KEY_WIDTH-1:0]   rd_data_ff;
   logic [ADDR_WIDTH-1:0]         rd_addr;

   logic [COUNT_WIDTH-1:0]        entry_count_ff;
   logic signed [KEY_WIDTH-1:0]   key_ff, key_in;
   logic signed [KEY_WIDTH-1:0]   kl_ff, kl_in;
   logic signed [RANGE_WIDTH-1:0] lo_ff, lo_in;
   logic signed [RANGE_WIDTH-1:0] hi_ff, hi_in;
   logic [ADDR_WIDTH-1:0]         p_ff, p_in;
   logic [PROD_WIDTH-1:0]         prod_ff, prod_in;
   logic [KEY_WIDTH-1:0]          den_ff, den_in;
   logic [KEY_WIDTH-1:0]          rem_ff, rem_in;
   logic [ADDR_WIDTH-1:0]         quo_ff, quo_in;
   logic                          res_found_ff, res_found_in;
   logic [ADDR_WIDTH-1:0]         res_pos_ff, res_pos_in;
   logic                          found_ff;
   logic [POS_WIDTH-1:0]          position_ff;

   logic [RANGE_WIDTH-1:0]        count_sat;
   logic signed [KEY_WIDTH:0]     key_diff;
   logic signed [KEY_WIDTH:0]     end_diff;
   logic [RANGE_WIDTH-1:0]        span;
   logic [KEY_WIDTH:0]            div_shift;
   logic [KEY_WIDTH:0]            div_sub;
   logic                          div_ge;

   // Entries above the table depth are clamped.
   assign count_sat = (entry_count_ff > COUNT_WIDTH'(TABLE_DEPTH)) ?
                      RANGE_WIDTH'(TABLE_DEPTH) : RANGE_WIDTH'(entry_count_ff);

   assign key_diff  = {key_ff[KEY_WIDTH-1], key_ff} - {kl_ff[KEY_WIDTH-1], kl_ff};
   assign end_diff  = {rd_data_ff[KEY_WIDTH-1], rd_data_ff} - {kl_ff[KEY_WIDTH-1], kl_ff};
   assign span      = hi_ff - lo_ff;
   assign div_shift = {rem_ff, quo_ff[ADDR_WIDTH-1]};
   assign div_sub   = div_shift - {1'b0, den_ff};
   assign div_ge    = div_shift >= {1'b0, den_ff};

   always_comb begin
      case (cmd.rd_sel)
         RD_LO:   rd_addr = lo_ff[ADDR_WIDTH-1:0];
         RD_HI:   rd_addr = hi_ff[ADDR_WIDTH-1:0];
         RD_P:    rd_addr = p_ff;
         default: rd_addr = p_ff;
      endcase
   end

   always_comb begin
      key_in       = key_ff;
      kl_in        = kl_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      p_in         = p_ff;
      prod_in      = prod_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      res_found_in = res_found_ff;
      res_pos_in   = res_pos_ff;

      if (cmd.init) begin
         key_in = key_value;
         lo_in  = '0;
         hi_in  = count_sat - RANGE_WIDTH'(1);
      end
      if (cmd.ld_kl) begin
         kl_in = rd_data_ff;
      end
      // The key lies between the end keys here, so both factors are non-negative
      // and the quotient cannot exceed the span.
      if (cmd.ld_mul) begin
         prod_in = {{ADDR_WIDTH{1'b0}}, key_diff[KEY_WIDTH-1:0]} *
                   {{KEY_WIDTH{1'b0}}, span[ADDR_WIDTH-1:0]};
         den_in  = end_diff[KEY_WIDTH-1:0];
      end
      if (cmd.div_load) begin
         rem_in = prod_ff[PROD_WIDTH-1:ADDR_WIDTH];
         quo_in = prod_ff[ADDR_WIDTH-1:0];
      end
      if (cmd.div_step) begin
         rem_in = div_ge ? div_sub[KEY_WIDTH-1:0] : div_shift[KEY_WIDTH-1:0];
         quo_in = {quo_ff[ADDR_WIDTH-2:0], div_ge};
      end
      if (cmd.p_from_lo) begin
         p_in = lo_ff[ADDR_WIDTH-1:0];
      end
      if (cmd.p_from_quo) begin
         p_in = lo_ff[ADDR_WIDTH-1:0] + quo_ff;
      end
      if (cmd.lo_up) begin
         lo_in = {2'b00, p_ff} + RANGE_WIDTH'(1);
      end
      if (cmd.hi_down) begin
         hi_in = {2'b00, p_ff} - RANGE_WIDTH'(1);
      end

      case (cmd.res_sel)
         RES_MISS: begin
            res_found_in = 1'b0;
            res_pos_in   = '0;
         end
         RES_LO: begin
            res_found_in = 1'b1;
            res_pos_in   = lo_ff[ADDR_WIDTH-1:0];
         end
         RES_P: begin
            res_found_in = 1'b1;
            res_pos_in   = p_ff;
         end
         default: begin
            res_found_in = res_found_ff;
            res_pos_in   = res_pos_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en && ({1'b0, entry_index} < (INDEX_WIDTH + 1)'(TABLE_DEPTH))) begin
         key_mem[entry_index[ADDR_WIDTH-1:0]] <= key_value;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= key_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_write_enable) begin
         entry_count_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      kl_ff        <= kl_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      p_ff         <= p_in;
      prod_ff      <= prod_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
      if (cmd.load_rsp) begin
         found_ff    <= res_found_ff;
         position_ff <= POS_WIDTH'(res_pos_ff);
      end
   end

   assign status.lo_le_hi = lo_ff <= hi_ff;
   assign status.in_range = (key_ff >= kl_ff) && (key_ff <= rd_data_ff);
   assign status.single   = lo_ff == hi_ff;
   assign status.match_lo = kl_ff == key_ff;
   assign status.flat     = rd_data_ff == kl_ff;
   assign status.p_match  = rd_data_ff == key_ff;
   assign status.p_below  = rd_data_ff < key_ff;

   assign found    = found_ff;
   assign position = position_ff;

endmodule

// ===== sv/ise_controller.sv =====
// Controller: sequences the probes of one search and owns the handshakes.
`timescale 1ns / 1ps

module ise_controller import ise_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_operation,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  ise_status_type status,
   output ise_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOOP,
      S_READ_HI,
      S_CHECK,
      S_DIV_LOAD,
      S_DIV,
      S_POS,
      S_READ_P,
      S_COMPARE,
      S_FINISH
   } state_type;

   state_type                state_ff, state_in;
   logic [DIV_CNT_WIDTH-1:0] div_cnt_ff, div_cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     req_accept;

   assign req_ready  = state_ff == S_IDLE;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      cmd.rd_sel  = RD_LO;
      cmd.res_sel = RES_NONE;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_operation == OP_SEARCH) begin
                  cmd.init = 1'b1;
                  state_in = S_LOOP;
               end else begin
                  cmd.wr_en = 1'b1;
               end
            end
         end
         S_LOOP: begin
            if (status.lo_le_hi) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_LO;
               state_in   = S_READ_HI;
            end else begin
               cmd.res_sel = RES_MISS;
               state_in    = S_FINISH;
            end
         end
         S_READ_HI: begin
            // Read data now holds the left key; fetch the right one.
            cmd.ld_kl  = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_HI;
            state_in   = S_CHECK;
         end
         S_CHECK: begin
            if (!status.in_range) begin
               cmd.res_sel = RES_MISS;
               state_in    = S_FINISH;
            end else if (status.single) begin
               cmd.res_sel = status.match_lo ? RES_LO : RES_MISS;
               state_in    = S_FINISH;
            end else if (status.flat) begin
               // Equal end keys: probe the left end instead of dividing by zero.
               cmd.p_from_lo = 1'b1;
               state_in      = S_READ_P;
            end else begin
               cmd.ld_mul = 1'b1;
               state_in   = S_DIV_LOAD;
            end
         end
         S_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            div_cnt_in   = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + DIV_CNT_WIDTH'(1);
            if (div_cnt_ff == DIV_CNT_WIDTH'(DIV_STEPS - 1)) begin
               state_in = S_POS;
            end
         end
         S_POS: begin
            cmd.p_from_quo = 1'b1;
            state_in       = S_READ_P;
         end
         S_READ_P: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_P;
            state_in   = S_COMPARE;
         end
         S_COMPARE: begin
            if (status.p_match) begin
               cmd.res_sel = RES_P;
               state_in    = S_FINISH;
            end else if (status.p_below) begin
               cmd.lo_up = 1'b1;
               state_in  = S_LOOP;
            end else begin
               cmd.hi_down = 1'b1;
               state_in    = S_LOOP;
            end
         end
         S_FINISH: begin
            // Wait until the output register is free or drains this cycle.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/interpolation_search_engine.sv =====
// Top level of the interpolation search engine: controller plus datapath.
//
//   Channel    Direction  Transfer contents
//   req_chan   in         operation, entry_index, key_value
//   rsp_chan   out        found, position (one per search, none per write)
//   csr_*      in         entry_count, written when csr_write_enable is high
//
// A write is done in the idle state, which it does not leave. Every probe of a search makes
// three reads of the single-port key memory; a probe that divides also runs the 10-step
// restoring divider, and a probe over equal end keys skips it. A search that misses ends
// with a range check, and every search ends by loading the output register. Reset is
// synchronous and clears control state and entry_count only; the key memory is not
// cleared. A finished result waits in the output register while the response side
// stalls; new requests are still taken, and a later search waits until the register drains.
`timescale 1ns / 1ps

module interpolation_search_engine import ise_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   ise_req_if.sink                req_chan,
   ise_rsp_if.source              rsp_chan,
   input  logic                   csr_write_enable,
   input  logic [COUNT_WIDTH-1:0] csr_write_data
);

   ise_cmd_type    cmd;
   ise_status_type status;

   ise_controller u_controller (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_operation (req_chan.operation),
      .req_ready     (req_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .status        (status),
      .cmd           (cmd)
   );

   ise_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .entry_index      (req_chan.entry_index),
      .key_value        (req_chan.key_value),
      .cmd              (cmd),
      .status           (status),
      .found            (rsp_chan.found),
      .position         (rsp_chan.position)
   );

endmodule

// ===== sv/ise_checker.sv =====
// Port-level assertions for the interpolation search engine and their bind.
`timescale 1ns / 1ps

module ise_checker import ise_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 req_operation,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_found,
   input logic [POS_WIDTH-1:0] rsp_position
);

   // A stalled response holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) && $stable(rsp_position))
      else $error("stalled response changed");

   // A miss always reports position zero.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_position == '0)
      else $error("miss with nonzero position");

   // Once a search is taken, no further request is taken on the next edge.
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == OP_SEARCH |=> !req_ready)
      else $error("request taken while a search runs");

   // A write transfer never produces a response.
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == OP_WRITE && !rsp_valid |=> !rsp_valid)
      else $error("response after a write");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind interpolation_search_engine ise_checker u_ise_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_operation (req_chan.operation),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_found     (rsp_chan.found),
   .rsp_position  (rsp_chan.position)
);
